[src/flt_pkg.sv]
// shared types, codes and sizes for the fault latch table
package flt_pkg;

    localparam int NUM_FAULTS = 128;
    localparam int IDX_W      = (NUM_FAULTS > 2) ? $clog2(NUM_FAULTS) : 1;
    localparam int MAP_W      = 64;
    localparam int APB_ADDR_W = 3;
    localparam int APB_DATA_W = 32;
    localparam int CFG_SEL_BIT = 2;

    localparam logic [15:0] COUNT_MAX = 16'hFFFF;

    // request codes
    localparam logic [1:0] REQ_UPDATE = 2'd0;
    localparam logic [1:0] REQ_CLEAR  = 2'd1;
    localparam logic [1:0] REQ_READ   = 2'd2;

    // reset policy codes
    localparam logic [1:0] POL_MANUAL = 2'd0;
    localparam logic [1:0] POL_AUTO   = 2'd1;
    localparam logic [1:0] POL_CAN    = 2'd2;

    // configuration register select (paddr bit 2)
    localparam logic CFG_CRIT_MIN = 1'b0;
    localparam logic CFG_HV_SEV   = 1'b1;

    typedef struct packed {
        logic [1:0]  req_type;
        logic [6:0]  fault_num;
        logic [2:0]  severity_code;
        logic [1:0]  reset_policy;
        logic        condition_now;
        logic [31:0] time_ms;
    } req_word_t;

    typedef struct packed {
        logic             clear_accepted;
        logic             critical_any;
        logic             hv_hard_any;
        logic [MAP_W-1:0] active_map_low;
        logic [MAP_W-1:0] active_map_high;
        logic [MAP_W-1:0] latched_map_low;
        logic [MAP_W-1:0] latched_map_high;
        logic             entry_active;
        logic             entry_latched;
        logic [15:0]      entry_count;
        logic [31:0]      entry_first_seen;
        logic [31:0]      entry_last_seen;
    } rsp_word_t;

    // one entry of the record memory
    typedef struct packed {
        logic [1:0]  policy;
        logic [31:0] last_seen;
        logic [31:0] first_seen;
        logic [15:0] count;
    } rec_t;

endpackage

[src/flt_req_if.sv]
// request channel: valid, ready and one request word
interface flt_req_if;
    import flt_pkg::*;

    logic      valid;
    logic      ready;
    req_word_t payload;

    modport source (output valid, output payload, input ready);
    modport sink   (input valid, input payload, output ready);
endinterface

[src/flt_rsp_if.sv]
// response channel: valid, ready and one result word
interface flt_rsp_if;
    import flt_pkg::*;

    logic      valid;
    logic      ready;
    rsp_word_t payload;

    modport source (output valid, output payload, input ready);
    modport sink   (input valid, input payload, output ready);
endinterface

[src/fault_latch_table.sv]
// fault latch table top level: request register, update logic, result register
//
//  channel | dir | handshake       | word
//  --------+-----+-----------------+--------------------------------------------
//  req     | in  | valid/ready     | req_type, fault_num, severity, policy,
//          |     |                 | condition, time
//  rsp     | out | valid/ready     | clear flag, summaries, maps, entry record
//  apb     | in  | psel/penable    | two 3-bit severity limits, paddr bit 2
//
// one word a cycle while the result is not stalled; a taken request passes the request stage, then the result register
// the record memory is read at accept time and written back when the word leaves the request stage,
// a same-entry follow-on word takes the written value through a bypass
// reset clears flags and record valid bits and loads the limits (2 and 3) at once,
// so no clearing pass is needed and words are taken straight after reset
// a stalled result holds the request stage; with both full, req.ready drops
module fault_latch_table (
    input  logic                              clk,
    input  logic                              rst_n,
    input  logic                              psel,
    input  logic                              penable,
    input  logic                              pwrite,
    input  logic [flt_pkg::APB_ADDR_W-1:0]    paddr,
    input  logic [flt_pkg::APB_DATA_W-1:0]    pwdata,
    output logic [flt_pkg::APB_DATA_W-1:0]    prdata,
    output logic                              pready,
    flt_req_if.sink                           req,
    flt_rsp_if.source                         rsp
);
    import flt_pkg::*;

    // configuration
    logic [2:0] crit_min_reg;
    logic [2:0] hv_sev_reg;
    logic       cfg_wr;

    // request stage
    logic       s1_valid_reg;
    req_word_t  s1_req_reg;
    rec_t       rd_raw_reg;     // registered memory read
    logic       fwd_hit_reg;    // previous word wrote this entry
    rec_t       fwd_rec_reg;

    // result stage
    logic       out_valid_reg;
    rsp_word_t  out_word_reg;

    // table state
    logic [NUM_FAULTS-1:0] active_reg;
    logic [NUM_FAULTS-1:0] latched_reg;
    logic [NUM_FAULTS-1:0] seen_reg;      // record memory entry has been written
    logic [2:0]            sev_reg [NUM_FAULTS];
    rec_t                  rec_mem [NUM_FAULTS];

    logic [NUM_FAULTS-1:0] active_next;
    logic [NUM_FAULTS-1:0] latched_next;

    logic                  advance;
    logic                  take;
    logic [IDX_W-1:0]      s1_addr;
    logic [IDX_W-1:0]      in_addr;
    logic                  hit;
    logic                  is_upd;
    logic                  is_clr;
    logic                  commit_upd;
    rec_t                  old_rec;
    rec_t                  rec_new;
    logic                  clear_ok;
    logic                  crit_any;
    logic                  hv_any;
    logic [2*MAP_W-1:0]    act_map;
    logic [2*MAP_W-1:0]    lat_map;
    logic [2:0]            sev_eff;
    rsp_word_t             word;

    // ---------------------------------------------------------------
    // apb register file
    // ---------------------------------------------------------------
    assign pready = 1'b1;
    assign cfg_wr = psel & penable & pwrite & pready;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            crit_min_reg <= 3'd2;
            hv_sev_reg   <= 3'd3;
        end
        else if (cfg_wr)
        begin
            unique case (paddr[CFG_SEL_BIT])
                CFG_CRIT_MIN: crit_min_reg <= pwdata[2:0];
                CFG_HV_SEV:   hv_sev_reg   <= pwdata[2:0];
            endcase
        end
    end

    always_comb
    begin
        unique case (paddr[CFG_SEL_BIT])
            CFG_CRIT_MIN: prdata = {{(APB_DATA_W-3){1'b0}}, crit_min_reg};
            CFG_HV_SEV:   prdata = {{(APB_DATA_W-3){1'b0}}, hv_sev_reg};
        endcase
    end

    // ---------------------------------------------------------------
    // handshake: request stage moves on when the result register frees
    // ---------------------------------------------------------------
    assign advance   = s1_valid_reg & (~out_valid_reg | rsp.ready);
    assign req.ready = ~s1_valid_reg | advance;
    assign take      = req.valid & req.ready;

    assign s1_addr = s1_req_reg.fault_num[IDX_W-1:0];
    assign in_addr = req.payload.fault_num[IDX_W-1:0];

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s1_valid_reg <= 1'b0;
            fwd_hit_reg  <= 1'b0;
        end
        else
        begin
            if (take)
            begin
                s1_valid_reg <= 1'b1;
                fwd_hit_reg  <= commit_upd & (s1_addr == in_addr);
            end
            else if (advance)
            begin
                s1_valid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (take)
        begin
            s1_req_reg  <= req.payload;
            fwd_rec_reg <= rec_new;
        end
    end

    // record memory: one write port, one registered read port
    always_ff @(posedge clk)
    begin
        if (commit_upd)
        begin
            rec_mem[s1_addr] <= rec_new;
        end
        if (take)
        begin
            rd_raw_reg <= rec_mem[in_addr];
        end
    end

    // ---------------------------------------------------------------
    // update logic for the word in the request stage
    // ---------------------------------------------------------------
    assign hit = (s1_req_reg.fault_num != 7'd0)
               && (32'(s1_req_reg.fault_num) < NUM_FAULTS);

    always_comb
    begin
        is_upd = 1'b0;
        is_clr = 1'b0;
        unique case (s1_req_reg.req_type)
            REQ_UPDATE: is_upd = 1'b1;
            REQ_CLEAR:  is_clr = 1'b1;
            REQ_READ:   is_upd = 1'b0;
            default:    is_upd = 1'b0;   // unused code reads only
        endcase
    end

    assign commit_upd = advance & hit & is_upd;

    // a never-written entry reads as zero; bypass covers back-to-back writes
    always_comb
    begin
        if (fwd_hit_reg)
            old_rec = fwd_rec_reg;
        else if (seen_reg[s1_addr])
            old_rec = rd_raw_reg;
        else
            old_rec = '0;
    end

    always_comb
    begin
        active_next  = active_reg;
        latched_next = latched_reg;
        rec_new      = old_rec;
        clear_ok     = 1'b0;

        if (hit && is_upd)
        begin
            rec_new.policy = s1_req_reg.reset_policy;
            if (s1_req_reg.condition_now)
            begin
                // rising edge of the condition: onset time and count
                if (!active_reg[s1_addr])
                begin
                    rec_new.first_seen = s1_req_reg.time_ms;
                    if (old_rec.count != COUNT_MAX)
                        rec_new.count = old_rec.count + 16'd1;
                end
                active_next[s1_addr]  = 1'b1;
                latched_next[s1_addr] = 1'b1;
                rec_new.last_seen     = s1_req_reg.time_ms;
            end
            else
            begin
                active_next[s1_addr] = 1'b0;
                if (s1_req_reg.reset_policy == POL_AUTO)
                    latched_next[s1_addr] = 1'b0;
            end
        end
        else if (hit && is_clr)
        begin
            // bus clear only for an inactive entry with the CAN policy
            if (!active_reg[s1_addr] && (old_rec.policy == POL_CAN))
            begin
                latched_next[s1_addr] = 1'b0;
                clear_ok              = 1'b1;
            end
        end
    end

    // severity summaries over the whole table after the step
    always_comb
    begin
        crit_any = 1'b0;
        hv_any   = 1'b0;
        sev_eff  = '0;
        for (int i = 0; i < NUM_FAULTS; i++)
        begin
            if (hit && is_upd && (s1_addr == IDX_W'(i)))
                sev_eff = s1_req_reg.severity_code;
            else
                sev_eff = sev_reg[i];
            if (active_next[i] || latched_next[i])
            begin
                if (sev_eff >= crit_min_reg)
                    crit_any = 1'b1;
                if (sev_eff == hv_sev_reg)
                    hv_any = 1'b1;
            end
        end
    end

    // flag maps, entries past the table size read as zero
    always_comb
    begin
        act_map = '0;
        lat_map = '0;
        for (int n = 0; n < NUM_FAULTS; n++)
        begin
            act_map[n] = active_next[n];
            lat_map[n] = latched_next[n];
        end
    end

    always_comb
    begin
        word                  = '0;
        word.clear_accepted   = clear_ok;
        word.critical_any     = crit_any;
        word.hv_hard_any      = hv_any;
        word.active_map_low   = act_map[MAP_W-1:0];
        word.active_map_high  = act_map[2*MAP_W-1:MAP_W];
        word.latched_map_low  = lat_map[MAP_W-1:0];
        word.latched_map_high = lat_map[2*MAP_W-1:MAP_W];
        if (hit)
        begin
            word.entry_active     = active_next[s1_addr];
            word.entry_latched    = latched_next[s1_addr];
            word.entry_count      = rec_new.count;
            word.entry_first_seen = rec_new.first_seen;
            word.entry_last_seen  = rec_new.last_seen;
        end
    end

    // ---------------------------------------------------------------
    // table state commit
    // ---------------------------------------------------------------
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            active_reg  <= '0;
            latched_reg <= '0;
            seen_reg    <= '0;
        end
        else if (advance)
        begin
            active_reg  <= active_next;
            latched_reg <= latched_next;
            if (hit && is_upd)
                seen_reg[s1_addr] <= 1'b1;
        end
    end

    // severity is only looked at under a set flag, which needs an update first
    always_ff @(posedge clk)
    begin
        if (commit_upd)
            sev_reg[s1_addr] <= s1_req_reg.severity_code;
    end

    // ---------------------------------------------------------------
    // result register
    // ---------------------------------------------------------------
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            out_valid_reg <= 1'b0;
        else if (advance)
            out_valid_reg <= 1'b1;
        else if (rsp.ready)
            out_valid_reg <= 1'b0;
    end

    always_ff @(posedge clk)
    begin
        if (advance)
            out_word_reg <= word;
    end

    assign rsp.valid   = out_valid_reg;
    assign rsp.payload = out_word_reg;

`ifndef SYNTHESIS
    a_active_implies_latched: assert property (@(posedge clk) disable iff (!rst_n)
        (active_reg & ~latched_reg) == '0)
        else $error("active entry without latched flag");

    a_entry_zero_idle: assert property (@(posedge clk) disable iff (!rst_n)
        !active_reg[0] && !latched_reg[0])
        else $error("entry zero flagged");

    a_clear_leaves_idle: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid_reg && out_word_reg.clear_accepted
        |-> !out_word_reg.entry_active && !out_word_reg.entry_latched)
        else $error("accepted clear left entry flagged");

    a_stage_holds: assert property (@(posedge clk) disable iff (!rst_n)
        s1_valid_reg && out_valid_reg && !rsp.ready
        |=> s1_valid_reg && $stable(s1_req_reg))
        else $error("request stage lost its word under stall");
`endif

endmodule
